@@ hw/rtl/crru_pkg.sv @@
`timescale 1ns / 1ps

package crru_pkg;

  localparam int RANK_W  = 30;
  localparam int REM_W   = RANK_W + 1;  // rank + 1
  localparam int NORB_W  = 6;
  localparam int NELEC_W = 5;
  localparam int ORB_W   = 6;
  localparam int SLOTF_W = 4;
  localparam int CFG_W   = 6;

  // register indexes on the config port
  localparam logic [0:0] CFG_NUM_ORBITALS  = 1'b0;
  localparam logic [0:0] CFG_NUM_ELECTRONS = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               err;
    logic [NORB_W-1:0]  num_orb;
    logic [NELEC_W-1:0] num_elec;
  } item_ctl_t;

  // C(n,k) via Pascal's triangle, saturated to REM_W bits (only ever
  // compared against the remainder, at most rank + 1, which is always below the saturation value)
  function automatic logic [REM_W-1:0] binom_sat(int n, int k);
    longint unsigned row [0:63];
    int a;
    int b;
    for (a = 0; a < 64; a++) begin
      row[a] = 64'd0;
    end
    row[0] = 64'd1;
    for (a = 1; a <= n; a++) begin
      for (b = a; b >= 1; b--) begin
        row[b] = row[b] + row[b-1];
      end
    end
    if (k > n || k < 0) begin
      return '0;
    end
    if (row[k] >= (64'd1 << REM_W)) begin
      return '1;
    end
    return row[k][REM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/combination_rank_unrank_unit.sv @@
// From an accepted rank to its first word: entry register, then the compare and
// select-and-subtract registers of each slot, then the serialiser register. Throughput:
// bounded by the serialiser, num_electrons words per rank (one for an error), one word per
// cycle while out_tready is high; the slot pipeline takes a rank every cycle unless stalled
// and holds up to 2*MAX_ELECTRONS + 1 ranks while the serialiser drains. Reset: rst_n
// synchronous, active low; empties the pipeline, sets num_orbitals to 8, num_electrons to 4.
`timescale 1ns / 1ps

module combination_rank_unrank_unit #(
  parameter int MAX_ORBITALS  = 32,
  parameter int MAX_ELECTRONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  // rank in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [29:0] rank, [31:30] zero
  // occupied orbitals out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [5:0] orbital, [9:6] slot, [15:10] zero
  output logic        out_tlast,
  output logic [0:0]  out_tuser    // [0] error
);

  localparam int SLOT_W = (MAX_ELECTRONS > 1) ? $clog2(MAX_ELECTRONS) : 1;
  localparam logic [6:0] MAXO_L = 7'(MAX_ORBITALS);
  localparam logic [5:0] MAXE_L = 6'(MAX_ELECTRONS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [crru_pkg::NORB_W-1:0]  num_orb_r;
  logic [crru_pkg::NELEC_W-1:0] num_elec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_orb_r  <= crru_pkg::NORB_W'(8);
      num_elec_r <= crru_pkg::NELEC_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        crru_pkg::CFG_NUM_ORBITALS:  num_orb_r  <= cfg_wdata[crru_pkg::NORB_W-1:0];
        crru_pkg::CFG_NUM_ELECTRONS: num_elec_r <= cfg_wdata[crru_pkg::NELEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole slot pipeline moves as one; it only stalls when
  // its last stage holds a rank and the serialiser cannot take it.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic ser_free;

  crru_pkg::item_ctl_t                            ctl_c [MAX_ELECTRONS+1];
  logic [crru_pkg::REM_W-1:0]                     rem_c [MAX_ELECTRONS+1];
  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0]  orb_c [MAX_ELECTRONS+1];

  assign pipe_en   = !ctl_c[MAX_ELECTRONS].valid || ser_free;
  assign in_tready = pipe_en;

  // ---------------------------------------------------------------------------
  // Entry stage: geometry check, rem = rank + 1
  // ---------------------------------------------------------------------------
  crru_pkg::item_ctl_t        ctl_e_nxt;
  crru_pkg::item_ctl_t        ctl_e_r;
  logic [crru_pkg::REM_W-1:0] rem_e_r;
  logic                       geo_bad;

  always_comb begin
    geo_bad = (num_elec_r == '0) ||
              ({1'b0, num_elec_r} > num_orb_r) ||
              ({1'b0, num_orb_r} > MAXO_L) ||
              ({1'b0, num_elec_r} > MAXE_L);
    ctl_e_nxt.valid    = in_tvalid;
    ctl_e_nxt.err      = geo_bad;
    ctl_e_nxt.num_orb  = num_orb_r;
    ctl_e_nxt.num_elec = num_elec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
    end else if (pipe_en) begin
      ctl_e_r <= ctl_e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rem_e_r <= {1'b0, in_tdata[crru_pkg::RANK_W-1:0]} + crru_pkg::REM_W'(1);
    end
  end

  assign ctl_c[0] = ctl_e_r;
  assign rem_c[0] = rem_e_r;
  assign orb_c[0] = '0;

  // ---------------------------------------------------------------------------
  // Slot stages, highest slot first; slots at or above num_electrons pass through
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < MAX_ELECTRONS; s++) begin : g_slot
    crru_slot #(
      .MAX_ORBITALS  (MAX_ORBITALS),
      .MAX_ELECTRONS (MAX_ELECTRONS),
      .SLOT          (MAX_ELECTRONS - 1 - s)
    ) u_slot (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .ctl_i (ctl_c[s]),
      .rem_i (rem_c[s]),
      .orb_i (orb_c[s]),
      .ctl_o (ctl_c[s+1]),
      .rem_o (rem_c[s+1]),
      .orb_o (orb_c[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output serialiser: one word per slot in use, highest slot first; one word on error
  // ---------------------------------------------------------------------------
  logic                                          busy_r;
  logic                                          err_r;
  logic [SLOT_W-1:0]                             slot_r;
  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_r;
  logic                                          last_now;
  logic                                          load;

  assign last_now = err_r || (slot_r == '0);
  assign ser_free = !busy_r || (out_tready && last_now);
  assign load     = pipe_en && ctl_c[MAX_ELECTRONS].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      slot_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      err_r  <= ctl_c[MAX_ELECTRONS].err;
      slot_r <= SLOT_W'(ctl_c[MAX_ELECTRONS].num_elec - crru_pkg::NELEC_W'(1));
    end else if (busy_r && out_tready) begin
      if (last_now) begin
        busy_r <= 1'b0;
      end else begin
        slot_r <= slot_r - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      orb_r <= orb_c[MAX_ELECTRONS];
    end
  end

  logic [crru_pkg::ORB_W-1:0]   out_orb;
  logic [crru_pkg::SLOTF_W-1:0] out_slot;

  always_comb begin
    if (err_r) begin
      out_orb  = '0;
      out_slot = '0;
    end else begin
      out_orb  = orb_r[slot_r];
      out_slot = crru_pkg::SLOTF_W'(slot_r);
    end
  end

  assign out_tvalid   = busy_r;
  assign out_tdata    = {6'b0, out_slot, out_orb};
  assign out_tlast    = last_now;
  assign out_tuser[0] = err_r;

endmodule

@@ hw/rtl/crru_slot.sv @@
`timescale 1ns / 1ps

// One electron slot: compare stage, then select-and-subtract stage.
module crru_slot #(
  parameter int MAX_ORBITALS  = 32,
  parameter int MAX_ELECTRONS = 16,
  parameter int SLOT          = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  crru_pkg::item_ctl_t                         ctl_i,
  input  logic [crru_pkg::REM_W-1:0]                  rem_i,
  input  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_i,
  output crru_pkg::item_ctl_t                         ctl_o,
  output logic [crru_pkg::REM_W-1:0]                  rem_o,
  output logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_o
);

  // weights C(k, SLOT+1) for k = 0 .. MAX_ORBITALS
  logic [crru_pkg::REM_W-1:0] wcol [MAX_ORBITALS+1];

  for (genvar k = 0; k <= MAX_ORBITALS; k++) begin : g_w
    localparam logic [crru_pkg::REM_W-1:0] W = crru_pkg::binom_sat(k, SLOT + 1);
    assign wcol[k] = W;
  end

  // ---- stage A: compare ----
  logic [crru_pkg::REM_W-1:0]  lim;
  logic [MAX_ORBITALS-1:0]     hit_nxt;
  logic                        is_live;
  logic                        is_top;
  logic                        over;
  crru_pkg::item_ctl_t         ctl_a_nxt;
  logic                        live_a_nxt;

  always_comb begin
    lim = '0;
    for (int k = 0; k <= MAX_ORBITALS; k++) begin
      if (ctl_i.num_orb == crru_pkg::NORB_W'(k)) begin
        lim = wcol[k];
      end
    end
    for (int k = 0; k < MAX_ORBITALS; k++) begin
      hit_nxt[k] = (crru_pkg::NORB_W'(k) < ctl_i.num_orb) && (wcol[k] < rem_i);
    end
    is_live    = ctl_i.valid && !ctl_i.err && ({1'b0, ctl_i.num_elec} > 6'(SLOT));
    is_top     = ({1'b0, ctl_i.num_elec} == 6'(SLOT + 1));
    // range check happens at the highest slot in use: rank >= C(no, ne)
    over       = is_live && is_top && (rem_i > lim);
    ctl_a_nxt  = ctl_i;
    ctl_a_nxt.err = ctl_i.err | over;
    live_a_nxt = is_live && !over;
  end

  crru_pkg::item_ctl_t                          ctl_a_r;
  logic                                         live_a_r;
  logic [crru_pkg::REM_W-1:0]                   rem_a_r;
  logic [MAX_ORBITALS-1:0]                      hit_a_r;
  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r  <= '0;
      live_a_r <= 1'b0;
    end else if (en) begin
      ctl_a_r  <= ctl_a_nxt;
      live_a_r <= live_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r <= rem_i;
      hit_a_r <= hit_nxt;
      orb_a_r <= orb_i;
    end
  end

  // ---- stage B: highest hit, subtract its weight ----
  logic [crru_pkg::REM_W-1:0]                   sel_w;
  logic [crru_pkg::ORB_W-1:0]                   sel_orb;
  logic [crru_pkg::REM_W-1:0]                   rem_b_nxt;
  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_b_nxt;

  always_comb begin
    sel_w   = '0;
    sel_orb = '0;
    for (int k = 0; k < MAX_ORBITALS; k++) begin
      if (hit_a_r[k]) begin
        sel_w   = wcol[k];
        sel_orb = crru_pkg::ORB_W'(k + 1);
      end
    end
    rem_b_nxt = rem_a_r;
    orb_b_nxt = orb_a_r;
    if (live_a_r) begin
      rem_b_nxt       = rem_a_r - sel_w;
      orb_b_nxt[SLOT] = sel_orb;
    end
  end

  crru_pkg::item_ctl_t                          ctl_b_r;
  logic [crru_pkg::REM_W-1:0]                   rem_b_r;
  logic [MAX_ELECTRONS-1:0][crru_pkg::ORB_W-1:0] orb_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_b_r <= rem_b_nxt;
      orb_b_r <= orb_b_nxt;
    end
  end

  assign ctl_o = ctl_b_r;
  assign rem_o = rem_b_r;
  assign orb_o = orb_b_r;

endmodule
